// ----- src/isort_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_pkg
// shared constants and types for the insertion sorter cell chain
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int StoreDepth = 16;
    localparam int ValueWidth = 32;

    typedef logic signed [ValueWidth-1:0] value_t;

    // what one cell shows its neighbours
    typedef struct packed {
        value_t value;
        logic   valid;
        logic   move;
    } cell_link_t;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic   insert;
        logic   shift;
        value_t sample;
    } cell_ctl_t;

endpackage

// ----- src/isort_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_cell
// one slot of the sorting chain: compares against the broadcast word and
// takes its lower neighbour's word or the new word on insertion, or its
// upper neighbour's word while the set is read out
// ----------------------------------------------------------------------------
module isort_cell
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  isort_pkg::cell_ctl_t   ctl,
    input  isort_pkg::cell_link_t  prev,
    input  isort_pkg::cell_link_t  next,
    output isort_pkg::cell_link_t  link
);

    isort_pkg::value_t value_reg;
    isort_pkg::value_t value_next;
    logic              valid_reg;
    logic              valid_next;
    logic              move;

    // strictly greater, so equal words stay ahead of the new one
    assign move = !valid_reg || (value_reg > ctl.sample);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.shift)
        begin
            value_next = next.value;
            valid_next = next.valid;
        end
        else if (ctl.insert)
        begin
            if (move)
            begin
                value_next = prev.move ? prev.value : ctl.sample;
            end
            valid_next = valid_reg | prev.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value = value_reg;
    assign link.valid = valid_reg;
    assign link.move  = move;

endmodule

// ----- src/insertion_sorter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter_core
// streaming insertion sorter for signed 32-bit words built as a chain of cells
// ----------------------------------------------------------------------------
// Words arrive one per cycle while a set is collected: every cell compares the
// new word at once and the chain opens a gap at its ascending position. Once
// the word marked end_of_set is taken, the input stalls and the set leaves
// from the head of the chain, one word per cycle unless the output stalls;
// input is taken again in the cycle after the final word leaves. The chain
// holds 16 words; further words of a set are dropped and every output word
// of that set carries overflow_seen.
module insertion_sorter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic [31:0] sample_value,
    input  logic        end_of_set,
    output logic        sorted_valid,
    input  logic        sorted_stall,
    output logic [31:0] sorted_value,
    output logic        final_item,
    output logic        overflow_seen
);

    localparam int Depth = isort_pkg::StoreDepth;

    isort_pkg::cell_link_t link [Depth];
    isort_pkg::cell_link_t head_tie;
    isort_pkg::cell_link_t tail_tie;
    isort_pkg::cell_ctl_t  ctl;

    logic emitting_reg;
    logic emitting_next;
    logic dropped_reg;
    logic dropped_next;
    logic in_take;
    logic out_take;
    logic full;

    assign full     = link[Depth-1].valid;
    assign in_take  = sample_valid && !sample_stall;
    assign out_take = sorted_valid && !sorted_stall;

    // head acts as an always-valid neighbour that never moves
    assign head_tie.value = '0;
    assign head_tie.valid = 1'b1;
    assign head_tie.move  = 1'b0;
    assign tail_tie.value = '0;
    assign tail_tie.valid = 1'b0;
    assign tail_tie.move  = 1'b1;

    assign ctl.insert = in_take && !full;
    assign ctl.shift  = out_take;
    assign ctl.sample = $signed(sample_value);

    genvar gi;
    generate
        for (gi = 0; gi < Depth; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                isort_cell u_cell
                (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .ctl   (ctl),
                    .prev  (head_tie),
                    .next  (link[gi+1]),
                    .link  (link[gi])
                );
            end
            else if (gi == Depth - 1)
            begin : g_tail
                isort_cell u_cell
                (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .ctl   (ctl),
                    .prev  (link[gi-1]),
                    .next  (tail_tie),
                    .link  (link[gi])
                );
            end
            else
            begin : g_mid
                isort_cell u_cell
                (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .ctl   (ctl),
                    .prev  (link[gi-1]),
                    .next  (link[gi+1]),
                    .link  (link[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        emitting_next = emitting_reg;
        dropped_next  = dropped_reg;
        if (in_take)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            if (end_of_set)
            begin
                emitting_next = 1'b1;
            end
        end
        if (out_take && final_item)
        begin
            emitting_next = 1'b0;
            dropped_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emitting_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            emitting_reg <= emitting_next;
            dropped_reg  <= dropped_next;
        end
    end

    // the head cell is the output word register while emitting
    assign sample_stall  = emitting_reg;
    assign sorted_valid  = emitting_reg;
    assign sorted_value  = link[0].value;
    assign final_item    = !link[1].valid;
    assign overflow_seen = dropped_reg;

endmodule
